// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while reset is released.
`define PMFTL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PMFTL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pmftl_pkg.sv
package pmftl_pkg;

    localparam int NB  = 64;
    localparam int PPB = 64;
    localparam int NLP = 2048;

    localparam int BLK_W  = $clog2(NB);
    localparam int OFF_W  = $clog2(PPB);
    localparam int PPN_W  = BLK_W + OFF_W;
    localparam int LP_W   = $clog2(NLP);
    localparam int VC_W   = $clog2(PPB + 1);
    localparam int EC_W   = 16;
    localparam int CT_W   = 32;
    localparam int FC_W   = $clog2(NB + 1);
    localparam int NUM_W  = VC_W + CT_W;
    localparam int DEN_W  = $clog2(2 * PPB + 1);
    localparam int SCAN_W = $clog2(NB + 3);
    localparam int MAP_W  = 1 + PPN_W;

    // fixed field widths
    localparam int IN_LP_W  = 11;
    localparam int PHYS_W   = 12;
    localparam int GC_W     = 7;
    localparam int ST_W     = 2;
    localparam int RES_W    = 7;
    localparam int END_W    = 16;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [CFG_IX_W-1:0] CFG_RESERVE = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_POLICY  = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_ENDURE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_NOFREE   = 2'd2;

    typedef enum logic [1:0] {
        OP_INC       = 2'd0,
        OP_INC_CLOSE = 2'd1,
        OP_DEC       = 2'd2,
        OP_ERASE     = 2'd3
    } t_rmw_op;

    typedef struct packed {
        logic [VC_W-1:0] vc;
        logic [EC_W-1:0] ec;
        logic [CT_W-1:0] ct;
    } t_binfo;

    localparam int BI_W = $bits(t_binfo);

    typedef struct packed {
        logic             clr;
        logic             vld;
        logic             pol;
        logic             elig;
        logic [BLK_W-1:0] blk;
        logic [VC_W-1:0]  vc;
        logic [CT_W-1:0]  age;
    } t_sc_ctl;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] victim;
    } t_sc_res;

endpackage

// File: rtl/pmftl_ifs.sv
interface pmftl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [pmftl_pkg::IN_LP_W-1:0] logical_page;

    modport src (output valid, action, logical_page, input ready);
    modport snk (input valid, action, logical_page, output ready);
endinterface

interface pmftl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pmftl_pkg::PHYS_W-1:0] physical_page;
    logic                         mapped;
    logic [pmftl_pkg::ST_W-1:0]   status;
    logic [pmftl_pkg::GC_W-1:0]   gc_rounds;

    modport src (output valid, physical_page, mapped, status, gc_rounds, input ready);
    modport snk (input valid, physical_page, mapped, status, gc_rounds, output ready);
endinterface

// File: rtl/pmftl_ram.sv
module pmftl_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/pmftl_score.sv
module pmftl_score (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmftl_pkg::t_sc_ctl i_ctl,
    output pmftl_pkg::t_sc_res o_res
);
    import pmftl_pkg::*;

    logic [VC_W-1:0]         v_clip;
    logic [VC_W-1:0]         inv;
    logic [NUM_W-1:0]        n_num;
    logic [DEN_W-1:0]        n_den;
    logic                    r_a_v;
    logic [BLK_W-1:0]        r_a_blk;
    logic [NUM_W-1:0]        r_a_num;
    logic [DEN_W-1:0]        r_a_den;
    logic [NUM_W-1:0]        r_best_num;
    logic [DEN_W-1:0]        r_best_den;
    logic                    r_found;
    logic [BLK_W-1:0]        r_victim;
    logic [NUM_W+DEN_W-1:0]  prod_new;
    logic [NUM_W+DEN_W-1:0]  prod_best;

    // stage A: score as a fraction num/den
    always_comb begin
        v_clip = (i_ctl.vc > VC_W'(PPB)) ? VC_W'(PPB) : i_ctl.vc;
        inv    = VC_W'(PPB) - v_clip;
        if (i_ctl.pol) begin
            n_num = NUM_W'(inv) * NUM_W'(i_ctl.age);
            n_den = DEN_W'(PPB) + DEN_W'(v_clip);
        end else begin
            n_num = NUM_W'(inv);
            n_den = DEN_W'(1);
        end
    end

    // stage B: exact compare by cross products, strictly greater wins
    assign prod_new  = (NUM_W+DEN_W)'(r_a_num) * (NUM_W+DEN_W)'(r_best_den);
    assign prod_best = (NUM_W+DEN_W)'(r_best_num) * (NUM_W+DEN_W)'(r_a_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_a_v      <= 1'b0;
            r_found    <= 1'b0;
            r_best_num <= '0;
            r_best_den <= DEN_W'(1);
        end else begin
            r_a_v <= i_ctl.vld && i_ctl.elig;
            if (r_a_v && (prod_new > prod_best)) begin
                r_best_num <= r_a_num;
                r_best_den <= r_a_den;
                r_found    <= 1'b1;
                r_victim   <= r_a_blk;
            end
        end
        r_a_blk <= i_ctl.blk;
        r_a_num <= n_num;
        r_a_den <= n_den;
    end

    assign o_res.found  = r_found;
    assign o_res.victim = r_victim;
endmodule

// File: rtl/page_mapped_ftl_with_gc_core.sv
// Page-mapped flash translation layer with garbage collection. After reset the
// block clears every entry of the logical map and takes no request meanwhile
// (configuration writes are taken). A write searches for a free block when it
// opens one and drops an older copy when the page was mapped. Each collection
// round runs a victim scan, a copy pass over every page of the victim that moves
// each live page (with the free-block search when a move opens a block), and an
// erase of the victim. A result word still waiting in the output register holds
// the last state until it is taken. One sequencer drives one block-info memory
// port, one map port and one owner port, and a single scoring unit compares
// victims.
module page_mapped_ftl_with_gc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pmftl_req_if.snk                       i_req,
    pmftl_rsp_if.src                       o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pmftl_pkg::CFG_IX_W-1:0] i_cfg_idx,
    input  logic [pmftl_pkg::CFG_D_W-1:0]  i_cfg_wdata
);
    import pmftl_pkg::*;

    typedef enum logic [20:0] {
        S_CLR       = 21'h000001,
        S_IDLE      = 21'h000002,
        S_MAP_RD    = 21'h000004,
        S_MAP_DAT   = 21'h000008,
        S_GC_CHK    = 21'h000010,
        S_VSCAN     = 21'h000020,
        S_VDONE     = 21'h000040,
        S_CP_OWN    = 21'h000080,
        S_CP_OWNDAT = 21'h000100,
        S_CP_MAPDAT = 21'h000200,
        S_CP_NEXT   = 21'h000400,
        S_ERASE     = 21'h000800,
        S_PROG_MAP  = 21'h001000,
        S_PROG_DAT  = 21'h002000,
        S_PG_START  = 21'h004000,
        S_FIND      = 21'h008000,
        S_PG_WR     = 21'h010000,
        S_PG_DONE   = 21'h020000,
        S_RMW_RD    = 21'h040000,
        S_RMW_WR    = 21'h080000,
        S_DONE      = 21'h100000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    logic [RES_W-1:0]  r_cfg_res;
    logic              r_cfg_pol;
    logic [END_W-1:0]  r_cfg_end;

    logic [LP_W-1:0]   r_clr, n_clr;
    logic              r_act, n_act;
    logic [LP_W-1:0]   r_lp, n_lp;
    logic [CT_W-1:0]   r_clock, n_clock;
    logic [NB-1:0]     r_free, n_free;
    logic [FC_W-1:0]   r_free_cnt, n_free_cnt;
    logic [NB-1:0]     r_bi_ok, n_bi_ok;
    logic              r_open_v, n_open_v;
    logic [BLK_W-1:0]  r_open_blk, n_open_blk;
    logic [OFF_W-1:0]  r_open_off, n_open_off;
    logic [SCAN_W-1:0] r_cnt, n_cnt;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [GC_W-1:0]   r_rounds, n_rounds;
    logic [LP_W-1:0]   r_cp_lp, n_cp_lp;
    logic              r_ctx_gc, n_ctx_gc;
    logic [PPN_W-1:0]  r_np, n_np;
    logic              r_had_old, n_had_old;
    logic [PPN_W-1:0]  r_old_ppn, n_old_ppn;
    logic [BLK_W-1:0]  r_rmw_blk, n_rmw_blk;
    t_rmw_op           r_rmw_op, n_rmw_op;
    logic              r_s1_v;
    logic [BLK_W-1:0]  r_s1_blk;
    logic [BLK_W-1:0]  r_bi_ra_q;

    logic [PHYS_W-1:0] r_res_ppn, n_res_ppn;
    logic              r_res_map, n_res_map;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic              r_out_v, n_out_v;
    logic [PHYS_W-1:0] r_out_ppn, n_out_ppn;
    logic              r_out_map, n_out_map;
    logic [ST_W-1:0]   r_out_st, n_out_st;
    logic [GC_W-1:0]   r_out_gc, n_out_gc;

    // memory ports
    logic              map_we;
    logic [LP_W-1:0]   map_wa, map_ra;
    logic [MAP_W-1:0]  map_wd, map_rd;
    logic              own_we;
    logic [PPN_W-1:0]  own_wa, own_ra;
    logic [LP_W-1:0]   own_wd, own_rd;
    logic              bi_we;
    logic [BLK_W-1:0]  bi_wa, bi_ra;
    t_binfo            bi_wd, bi_raw, bi_rd;

    t_sc_ctl           sc_ctl;
    t_sc_res           sc_res;
    logic [PPN_W-1:0]  cp_ppn;
    logic [PPN_W-1:0]  new_ppn;

    pmftl_ram #(.W(MAP_W), .D(NLP)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(map_ra), .o_rdata(map_rd)
    );

    pmftl_ram #(.W(LP_W), .D(NB * PPB)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_wa), .i_wdata(own_wd),
        .i_raddr(own_ra), .o_rdata(own_rd)
    );

    pmftl_ram #(.W(BI_W), .D(NB)) u_binfo (
        .i_clk(i_clk), .i_we(bi_we), .i_waddr(bi_wa), .i_wdata(bi_wd),
        .i_raddr(bi_ra), .o_rdata(bi_raw)
    );

    pmftl_score u_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sc_ctl), .o_res(sc_res)
    );

    // never-written entries read as zero
    assign bi_rd   = r_bi_ok[r_bi_ra_q] ? bi_raw : '0;
    assign cp_ppn  = {sc_res.victim, r_off};
    assign new_ppn = {r_open_blk, r_open_off};

    always_comb begin
        sc_ctl.clr  = (r_state == S_GC_CHK);
        sc_ctl.vld  = r_s1_v;
        sc_ctl.pol  = r_cfg_pol;
        sc_ctl.blk  = r_s1_blk;
        sc_ctl.vc   = bi_rd.vc;
        sc_ctl.age  = r_clock - bi_rd.ct;
        sc_ctl.elig = !r_free[r_s1_blk] && !(r_open_v && (r_s1_blk == r_open_blk))
                      && (bi_rd.ec < r_cfg_end);
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_v;
    assign o_rsp.physical_page = r_out_ppn;
    assign o_rsp.mapped        = r_out_map;
    assign o_rsp.status        = r_out_st;
    assign o_rsp.gc_rounds     = r_out_gc;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_clr      = r_clr;
        n_act      = r_act;
        n_lp       = r_lp;
        n_clock    = r_clock;
        n_free     = r_free;
        n_free_cnt = r_free_cnt;
        n_bi_ok    = r_bi_ok;
        n_open_v   = r_open_v;
        n_open_blk = r_open_blk;
        n_open_off = r_open_off;
        n_cnt      = r_cnt;
        n_off      = r_off;
        n_rounds   = r_rounds;
        n_cp_lp    = r_cp_lp;
        n_ctx_gc   = r_ctx_gc;
        n_np       = r_np;
        n_had_old  = r_had_old;
        n_old_ppn  = r_old_ppn;
        n_rmw_blk  = r_rmw_blk;
        n_rmw_op   = r_rmw_op;
        n_res_ppn  = r_res_ppn;
        n_res_map  = r_res_map;
        n_res_st   = r_res_st;
        n_out_v    = r_out_v && !o_rsp.ready;
        n_out_ppn  = r_out_ppn;
        n_out_map  = r_out_map;
        n_out_st   = r_out_st;
        n_out_gc   = r_out_gc;

        map_we = 1'b0;
        map_wa = r_lp;
        map_wd = {1'b1, r_np};
        map_ra = r_lp;
        own_we = 1'b0;
        own_wa = new_ppn;
        own_wd = r_ctx_gc ? r_cp_lp : r_lp;
        own_ra = cp_ppn;
        bi_we  = 1'b0;
        bi_wa  = r_rmw_blk;
        bi_wd  = bi_rd;
        bi_ra  = r_rmw_blk;

        case (r_state)
            S_CLR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = '0;
                n_clr  = r_clr + LP_W'(1);
                if (r_clr == LP_W'(NLP - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act    = i_req.action;
                    n_lp     = i_req.logical_page[LP_W-1:0];
                    n_rounds = '0;
                    if (i_req.action) begin
                        n_clock = r_clock + CT_W'(1);
                        n_state = S_GC_CHK;
                    end else begin
                        n_state = S_MAP_RD;
                    end
                end
            end
            S_MAP_RD: begin
                n_state = S_MAP_DAT;
            end
            S_MAP_DAT: begin
                n_res_map = map_rd[MAP_W-1];
                n_res_ppn = map_rd[MAP_W-1] ? PHYS_W'(map_rd[PPN_W-1:0]) : '0;
                n_res_st  = map_rd[MAP_W-1] ? ST_OK : ST_UNMAPPED;
                n_state   = S_DONE;
            end
            S_GC_CHK: begin
                if (r_open_v || (FC_W'(r_free_cnt) >= FC_W'(r_cfg_res))
                    && (RES_W'(r_free_cnt) >= r_cfg_res)) begin
                    n_state = S_PROG_MAP;
                end else begin
                    n_cnt   = '0;
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                bi_ra = r_cnt[BLK_W-1:0];
                n_cnt = r_cnt + SCAN_W'(1);
                if (r_cnt == SCAN_W'(NB + 2)) begin
                    n_state = S_VDONE;
                end
            end
            S_VDONE: begin
                if (sc_res.found) begin
                    n_off   = '0;
                    n_state = S_CP_OWN;
                end else begin
                    n_state = S_PROG_MAP;
                end
            end
            S_CP_OWN: begin
                n_state = S_CP_OWNDAT;
            end
            S_CP_OWNDAT: begin
                map_ra  = own_rd;
                n_cp_lp = own_rd;
                n_state = S_CP_MAPDAT;
            end
            S_CP_MAPDAT: begin
                // move the page only if the map still points here
                if (map_rd[MAP_W-1] && (map_rd[PPN_W-1:0] == cp_ppn)) begin
                    n_ctx_gc = 1'b1;
                    n_state  = S_PG_START;
                end else begin
                    n_state = S_CP_NEXT;
                end
            end
            S_CP_NEXT: begin
                if (r_off == OFF_W'(PPB - 1)) begin
                    n_state = S_ERASE;
                end else begin
                    n_off   = r_off + OFF_W'(1);
                    n_state = S_CP_OWN;
                end
            end
            S_ERASE: begin
                n_free[sc_res.victim] = 1'b1;
                n_free_cnt = r_free_cnt + FC_W'(1);
                if (r_rounds != '1) begin
                    n_rounds = r_rounds + GC_W'(1);
                end
                n_rmw_blk = sc_res.victim;
                n_rmw_op  = OP_ERASE;
                n_ret     = S_GC_CHK;
                n_state   = S_RMW_RD;
            end
            S_PROG_MAP: begin
                n_state = S_PROG_DAT;
            end
            S_PROG_DAT: begin
                n_had_old = map_rd[MAP_W-1];
                n_old_ppn = map_rd[PPN_W-1:0];
                n_ctx_gc  = 1'b0;
                n_state   = S_PG_START;
            end
            S_PG_START: begin
                n_cnt   = '0;
                n_state = r_open_v ? S_PG_WR : S_FIND;
            end
            S_FIND: begin
                if (r_free[r_cnt[BLK_W-1:0]]) begin
                    n_open_v   = 1'b1;
                    n_open_blk = r_cnt[BLK_W-1:0];
                    n_open_off = '0;
                    n_free[r_cnt[BLK_W-1:0]] = 1'b0;
                    n_free_cnt = r_free_cnt - FC_W'(1);
                    n_state    = S_PG_WR;
                end else if (r_cnt == SCAN_W'(NB - 1)) begin
                    if (r_ctx_gc) begin
                        // abandon the round, the write then fails too
                        if (r_rounds != '1) begin
                            n_rounds = r_rounds + GC_W'(1);
                        end
                        n_state = S_PROG_MAP;
                    end else begin
                        n_res_ppn = '0;
                        n_res_map = 1'b0;
                        n_res_st  = ST_NOFREE;
                        n_state   = S_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + SCAN_W'(1);
                end
            end
            S_PG_WR: begin
                own_we     = 1'b1;
                n_np       = new_ppn;
                n_open_off = r_open_off + OFF_W'(1);
                n_rmw_blk  = r_open_blk;
                if (r_open_off == OFF_W'(PPB - 1)) begin
                    n_open_v = 1'b0;
                    n_rmw_op = OP_INC_CLOSE;
                end else begin
                    n_rmw_op = OP_INC;
                end
                n_ret   = S_PG_DONE;
                n_state = S_RMW_RD;
            end
            S_PG_DONE: begin
                map_we = 1'b1;
                if (r_ctx_gc) begin
                    map_wa    = r_cp_lp;
                    n_rmw_blk = sc_res.victim;
                    n_rmw_op  = OP_DEC;
                    n_ret     = S_CP_NEXT;
                    n_state   = S_RMW_RD;
                end else begin
                    n_res_ppn = PHYS_W'(r_np);
                    n_res_map = 1'b1;
                    n_res_st  = ST_OK;
                    if (r_had_old) begin
                        n_rmw_blk = r_old_ppn[PPN_W-1:OFF_W];
                        n_rmw_op  = OP_DEC;
                        n_ret     = S_DONE;
                        n_state   = S_RMW_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                bi_we = 1'b1;
                n_bi_ok[r_rmw_blk] = 1'b1;
                case (r_rmw_op)
                    OP_INC: begin
                        bi_wd.vc = bi_rd.vc + VC_W'(1);
                    end
                    OP_INC_CLOSE: begin
                        bi_wd.vc = bi_rd.vc + VC_W'(1);
                        bi_wd.ct = r_clock;
                    end
                    OP_DEC: begin
                        if (bi_rd.vc != '0) begin
                            bi_wd.vc = bi_rd.vc - VC_W'(1);
                        end
                    end
                    OP_ERASE: begin
                        bi_wd.vc = '0;
                        if (bi_rd.ec != '1) begin
                            bi_wd.ec = bi_rd.ec + EC_W'(1);
                        end
                    end
                    default: begin
                        bi_wd = bi_rd;
                    end
                endcase
                n_state = r_ret;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_v || o_rsp.ready) begin
                    n_out_v   = 1'b1;
                    n_out_ppn = r_res_ppn;
                    n_out_map = r_res_map;
                    n_out_st  = r_res_st;
                    n_out_gc  = r_act ? r_rounds : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ret      <= S_IDLE;
            r_clr      <= '0;
            r_clock    <= '0;
            r_free     <= '1;
            r_free_cnt <= FC_W'(NB);
            r_bi_ok    <= '0;
            r_open_v   <= 1'b0;
            r_open_blk <= '0;
            r_open_off <= '0;
            r_out_v    <= 1'b0;
            r_s1_v     <= 1'b0;
            r_cfg_res  <= RES_W'(2);
            r_cfg_pol  <= 1'b0;
            r_cfg_end  <= END_W'(3000);
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_clr      <= n_clr;
            r_clock    <= n_clock;
            r_free     <= n_free;
            r_free_cnt <= n_free_cnt;
            r_bi_ok    <= n_bi_ok;
            r_open_v   <= n_open_v;
            r_open_blk <= n_open_blk;
            r_open_off <= n_open_off;
            r_out_v    <= n_out_v;
            r_s1_v     <= (r_state == S_VSCAN) && (r_cnt < SCAN_W'(NB));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RESERVE: r_cfg_res <= i_cfg_wdata[RES_W-1:0];
                    CFG_POLICY:  r_cfg_pol <= i_cfg_wdata[0];
                    CFG_ENDURE:  r_cfg_end <= i_cfg_wdata[END_W-1:0];
                    default: begin
                        r_cfg_res <= r_cfg_res;
                    end
                endcase
            end
        end
        r_act     <= n_act;
        r_lp      <= n_lp;
        r_cnt     <= n_cnt;
        r_off     <= n_off;
        r_rounds  <= n_rounds;
        r_cp_lp   <= n_cp_lp;
        r_ctx_gc  <= n_ctx_gc;
        r_np      <= n_np;
        r_had_old <= n_had_old;
        r_old_ppn <= n_old_ppn;
        r_rmw_blk <= n_rmw_blk;
        r_rmw_op  <= n_rmw_op;
        r_res_ppn <= n_res_ppn;
        r_res_map <= n_res_map;
        r_res_st  <= n_res_st;
        r_out_ppn <= n_out_ppn;
        r_out_map <= n_out_map;
        r_out_st  <= n_out_st;
        r_out_gc  <= n_out_gc;
        r_s1_blk  <= r_cnt[BLK_W-1:0];
        r_bi_ra_q <= bi_ra;
    end
endmodule

// File: rtl/pmftl_chk.sv
`include "assert_macros.svh"

module pmftl_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [pmftl_pkg::PHYS_W-1:0]   i_ppn,
    input logic                           i_mapped,
    input logic [pmftl_pkg::ST_W-1:0]     i_status,
    input logic [pmftl_pkg::GC_W-1:0]     i_gc
);
    import pmftl_pkg::*;

    // hold a stalled word
    `PMFTL_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_ppn) && $stable(i_status), "response dropped or changed while stalled")

    `PMFTL_ASSERT(a_map_status, i_clk, i_rst_n, i_rsp_valid |-> (i_mapped == (i_status == ST_OK)) && (i_mapped || (i_ppn == '0)), "mapped flag disagrees with status")

    `PMFTL_ASSERT(a_read_no_gc, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_UNMAPPED) |-> (i_gc == '0), "unmapped read reports collection rounds")

    `PMFTL_ASSERT(a_clear_pass, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_req_ready, "request taken before map clear finished")
endmodule

bind page_mapped_ftl_with_gc_core pmftl_chk u_pmftl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_ppn       (o_rsp.physical_page),
    .i_mapped    (o_rsp.mapped),
    .i_status    (o_rsp.status),
    .i_gc        (o_rsp.gc_rounds)
);

// File: tb/sv/page_mapped_ftl_with_gc_core_tb.sv
`default_nettype none

module page_mapped_ftl_with_gc_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmftl_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT = 20_000_000;
    localparam int   SETTLE_CYCLES = 200;

    typedef enum int {GC_NO_VICTIM, GC_ROUND_DONE, GC_ROUND_ABORT} t_gc_outcome;

    typedef struct packed {
        logic [PHYS_W-1:0] ppn;
        logic              mapped;
        logic [ST_W-1:0]   status;
        logic [GC_W-1:0]   gc_rounds;
    } t_ftl_rsp;

    typedef struct {
        logic              action;
        logic [IN_LP_W-1:0] lp;
        bit                known;
        t_ftl_rsp          rsp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IX_W-1:0] i_cfg_idx = '0;
    logic [CFG_D_W-1:0]  i_cfg_wdata = '0;

    pmftl_req_if req_if ();
    pmftl_rsp_if rsp_if ();

    page_mapped_ftl_with_gc_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned  reserve_cfg;
    bit           policy_cfg;
    int unsigned  endure_cfg;
    bit           map_vld [NLP];
    int unsigned  map_ppn [NLP];
    int unsigned  owner [NB*PPB];
    bit           is_user [NB*PPB];
    int unsigned  valid_cnt [NB];
    int unsigned  erase_cnt [NB];
    bit           blk_free [NB];
    bit [31:0]    closed_at [NB];
    bit           open_vld;
    int unsigned  open_blk;
    int unsigned  open_off;
    bit [31:0]    write_clk;

    t_ftl_rsp     expected_rsps [$];
    t_ftl_rsp     pending_dir [$];
    bit           pending_known [$];
    int           errors = 0;
    int           cycles = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           n_rsp = 0;
    int           n_gc_writes = 0;
    int           n_nofree = 0;

    function automatic void ftl_reset();
        reserve_cfg = 2;
        policy_cfg  = 1'b0;
        endure_cfg  = 3000;
        for (int i = 0; i < NLP; i++) begin
            map_vld[i] = 1'b0;
            map_ppn[i] = 0;
        end
        for (int i = 0; i < NB*PPB; i++) begin
            owner[i] = 0;
            is_user[i] = 1'b0;
        end
        for (int b = 0; b < NB; b++) begin
            valid_cnt[b] = 0;
            erase_cnt[b] = 0;
            blk_free[b]  = 1'b1;
            closed_at[b] = '0;
        end
        open_vld  = 1'b0;
        open_blk  = 0;
        open_off  = 0;
        write_clk = '0;
    endfunction

    function automatic bit program_page(int unsigned lp, output int unsigned ppn);
        int unsigned b;
        ppn = 0;
        if (!open_vld) begin
            b = 0;
            while (b < NB && !blk_free[b]) b++;
            if (b >= NB) return 1'b0;
            open_vld = 1'b1;
            open_blk = b;
            blk_free[b] = 1'b0;
            open_off = 0;
        end
        ppn = open_blk * PPB + open_off;
        owner[ppn] = lp;
        is_user[ppn] = 1'b1;
        open_off++;
        valid_cnt[open_blk]++;
        if (open_off >= PPB) begin
            closed_at[open_blk] = write_clk;
            open_vld = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void drop_page(int unsigned ppn);
        int unsigned b;
        b = (ppn / PPB) % NB;
        if (valid_cnt[b] > 0) valid_cnt[b]--;
    endfunction

    function automatic int unsigned pick_victim();
        int unsigned victim;
        longint unsigned best_num, best_den, v, num, den;
        bit [31:0] age;
        victim = NB;
        best_num = 0;
        best_den = 1;
        for (int b = 0; b < NB; b++) begin
            if (blk_free[b] || (open_vld && open_blk == b) || erase_cnt[b] >= endure_cfg)
                continue;
            v = (valid_cnt[b] > PPB) ? PPB : valid_cnt[b];
            if (!policy_cfg) begin
                num = PPB - v;
                den = 1;
            end else begin
                age = write_clk - closed_at[b];
                num = (PPB - v) * longint'(age);
                den = PPB + v;
            end
            // strict compare keeps lowest block on ties, never picks score zero
            if (num * best_den > best_num * den) begin
                best_num = num;
                best_den = den;
                victim = b;
            end
        end
        return victim;
    endfunction

    function automatic t_gc_outcome collect_round();
        int unsigned victim, ppn, lp, np;
        victim = pick_victim();
        if (victim >= NB) return GC_NO_VICTIM;
        for (int off = 0; off < PPB; off++) begin
            ppn = victim * PPB + off;
            if (!is_user[ppn]) continue;
            lp = owner[ppn] % NLP;
            if (!map_vld[lp] || map_ppn[lp] != ppn) continue;
            if (!program_page(lp, np)) return GC_ROUND_ABORT;
            map_ppn[lp] = np;
            drop_page(ppn);
        end
        for (int off = 0; off < PPB; off++) is_user[victim*PPB + off] = 1'b0;
        if (erase_cnt[victim] < 65535) erase_cnt[victim]++;
        valid_cnt[victim] = 0;
        blk_free[victim] = 1'b1;
        return GC_ROUND_DONE;
    endfunction

    function automatic t_ftl_rsp ftl_predict(logic action, logic [IN_LP_W-1:0] lp_in);
        t_ftl_rsp r;
        int unsigned lp, rounds, nfree, np, old_ppn;
        t_gc_outcome oc;
        bit had_old;
        r = '0;
        lp = lp_in % NLP;
        if (action == ACT_READ) begin
            if (map_vld[lp]) begin
                r.ppn = map_ppn[lp][PHYS_W-1:0];
                r.mapped = 1'b1;
            end else begin
                r.status = ST_UNMAPPED;
            end
            return r;
        end
        write_clk++;
        rounds = 0;
        while (!open_vld) begin
            nfree = 0;
            for (int b = 0; b < NB; b++) nfree += blk_free[b];
            if (nfree >= reserve_cfg) break;
            oc = collect_round();
            if (oc == GC_NO_VICTIM) break;
            rounds++;
            if (oc == GC_ROUND_ABORT) break;
        end
        r.gc_rounds = (rounds > 127) ? 7'd127 : rounds[GC_W-1:0];
        had_old = map_vld[lp];
        old_ppn = map_ppn[lp];
        if (!program_page(lp, np)) begin
            r.status = ST_NOFREE;
            return r;
        end
        if (had_old) drop_page(old_ppn);
        map_vld[lp] = 1'b1;
        map_ppn[lp] = np;
        r.ppn = np[PHYS_W-1:0];
        r.mapped = 1'b1;
        return r;
    endfunction

    // accept side feeds the predictor, result side checks against it
    always @(posedge i_clk) begin
        t_ftl_rsp exp_r, got;
        cycles <= cycles + 1;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            exp_r = ftl_predict(req_if.action, req_if.logical_page);
            if (pending_dir.size() > 0) begin
                if (pending_known.pop_front()) exp_r = pending_dir.pop_front();
                else void'(pending_dir.pop_front());
            end
            expected_rsps = {expected_rsps, exp_r};
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.ppn = rsp_if.physical_page;
            got.mapped = rsp_if.mapped;
            got.status = rsp_if.status;
            got.gc_rounds = rsp_if.gc_rounds;
            n_rsp++;
            if (got.gc_rounds != 0) n_gc_writes++;
            if (got.status == ST_NOFREE) n_nofree++;
            if (expected_rsps.size() == 0) begin
                $error("result word with nothing expected: ppn=%0d", got.ppn);
                errors++;
            end else begin
                exp_r = expected_rsps.pop_front();
                if (got.ppn != exp_r.ppn) begin
                    $error("physical_page: expected %0d actual %0d", exp_r.ppn, got.ppn);
                    errors++;
                end
                if (got.mapped != exp_r.mapped) begin
                    $error("mapped: expected %0d actual %0d", exp_r.mapped, got.mapped);
                    errors++;
                end
                if (got.status != exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.gc_rounds != exp_r.gc_rounds) begin
                    $error("gc_rounds: expected %0d actual %0d",
                           exp_r.gc_rounds, got.gc_rounds);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_word(logic action, logic [IN_LP_W-1:0] lp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.action <= action;
        req_if.logical_page <= lp;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic go_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IX_W-1:0] idx, int unsigned data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data[CFG_D_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RESERVE: reserve_cfg = data & 32'h7F;
            CFG_POLICY:  policy_cfg = data[0];
            CFG_ENDURE:  endure_cfg = data & 32'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned reserve, int unsigned policy, int unsigned endure);
        write_reg(CFG_RESERVE, reserve);
        write_reg(CFG_POLICY, policy);
        write_reg(CFG_ENDURE, endure);
    endtask

    function automatic t_dir_row dir_row(logic a, int unsigned lp, bit known,
                                         int unsigned ppn, bit mp, logic [ST_W-1:0] st);
        t_dir_row r;
        r.action = a;
        r.lp = lp[IN_LP_W-1:0];
        r.known = known;
        r.rsp.ppn = ppn[PHYS_W-1:0];
        r.rsp.mapped = mp;
        r.rsp.status = st;
        r.rsp.gc_rounds = '0;
        return r;
    endfunction

    task automatic random_burst(int count);
        int hot;
        logic [IN_LP_W-1:0] lp;
        hot = $urandom_range(16, 96);
        for (int i = 0; i < count; i++) begin
            // mostly rewrite a hot set so blocks gather invalid pages
            if ($urandom_range(9) < 8) lp = IN_LP_W'($urandom_range(hot - 1));
            else lp = IN_LP_W'($urandom_range(NLP - 1));
            send_word(($urandom_range(3) != 0) ? ACT_WRITE : ACT_READ, lp);
        end
    endtask

    initial begin
        t_dir_row rows [$];
        int idle_set [4] = '{0, 69, 0, 34};
        int stall_set [4] = '{0, 0, 69, 34};
        req_if.valid = 1'b0;
        req_if.action = ACT_READ;
        req_if.logical_page = '0;
        rsp_if.ready = 1'b0;
        ftl_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh map: unmapped reads, then sequential programming in block zero
        rows = {rows, dir_row(ACT_READ, 0, 1, 0, 0, ST_UNMAPPED)};
        rows = {rows, dir_row(ACT_READ, NLP - 1, 1, 0, 0, ST_UNMAPPED)};
        rows = {rows, dir_row(ACT_WRITE, 0, 1, 0, 1, ST_OK)};
        rows = {rows, dir_row(ACT_WRITE, NLP - 1, 1, 1, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, 0, 1, 0, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, NLP - 1, 1, 1, 1, ST_OK)};
        rows = {rows, dir_row(ACT_WRITE, 0, 1, 2, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, 0, 1, 2, 1, ST_OK)};
        rows = {rows, dir_row(ACT_WRITE, 11'h555, 1, 3, 1, ST_OK)};
        rows = {rows, dir_row(ACT_WRITE, 11'h2AA, 1, 4, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, 11'h555, 1, 3, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, 11'h2AA, 1, 4, 1, ST_OK)};
        rows = {rows, dir_row(ACT_READ, 11'h400, 1, 0, 0, ST_UNMAPPED)};
        for (int i = 0; i < rows.size(); i++) begin
            pending_dir = {pending_dir, rows[i].rsp};
            pending_known = {pending_known, rows[i].known};
        end
        foreach (rows[i]) send_word(rows[i].action, rows[i].lp);
        go_idle();

        // rewrite a tiny hot set under the widest reserve: collection every close
        set_config(64, 0, 65535);
        for (int i = 0; i < 12; i++) send_word(ACT_WRITE, IN_LP_W'(i % 4));
        go_idle();

        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            set_config(64, 0, 65535);
            random_burst(45);
            go_idle();
            set_config(62, 1, 3000);
            random_burst(45);
            go_idle();
            // tiny endurance: erased blocks drop out of the victim pool
            set_config($urandom_range(3, 64), p % 2, 1);
            random_burst(45);
            go_idle();
        end

        // back to the default reserve
        idle_pct = 0;
        stall_pct = 0;
        set_config(2, 0, 3000);
        for (int i = 0; i < 10; i++) send_word(ACT_WRITE, IN_LP_W'($urandom_range(NLP - 1)));
        go_idle();

        if (expected_rsps.size() != 0) begin
            $error("%0d expected result words never arrived", expected_rsps.size());
            errors++;
        end
        $display("Checked %0d result words under four idle/stall mixes and several settings,",
                 n_rsp);
        $display("  %0d writes ran collection, %0d hit a full device.", n_gc_writes, n_nofree);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/pmftl_pkg.sv
rtl/pmftl_ifs.sv
rtl/pmftl_ram.sv
rtl/pmftl_score.sv
rtl/page_mapped_ftl_with_gc_core.sv
rtl/pmftl_chk.sv
tb/sv/page_mapped_ftl_with_gc_core_tb.sv
